/* src/tred_pkg.sv */
`timescale 1ns / 1ps

package tred_pkg;

    // Input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_FAIL = 1'b1;

    // Result kinds
    localparam logic RK_POINT   = 1'b0;
    localparam logic RK_SUMMARY = 1'b1;

    // Raw event codes from record byte 0, bits [7:6]
    localparam logic [1:0] CODE_DOWN    = 2'd0;
    localparam logic [1:0] CODE_UP      = 2'd1;
    localparam logic [1:0] CODE_CONTACT = 2'd2;
    localparam logic [1:0] CODE_NONE    = 2'd3;

    // Reported touch events
    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_DOWN = 3'd1;
    localparam logic [2:0] EV_HOLD = 3'd2;
    localparam logic [2:0] EV_MOVE = 3'd3;
    localparam logic [2:0] EV_UP   = 3'd4;

    // Record layout
    localparam int unsigned RECORD_BYTES = 6;
    localparam logic [2:0] OFF_X_HIGH = 3'd0;
    localparam logic [2:0] OFF_X_LOW  = 3'd1;
    localparam logic [2:0] OFF_Y_HIGH = 3'd2;
    localparam logic [2:0] OFF_Y_LOW  = 3'd3;
    localparam logic [2:0] OFF_LAST   = 3'(RECORD_BYTES - 1);

    localparam logic [3:0] COUNT_MASK = 4'hf;

    typedef struct packed {
        logic       kind;
        logic       first_byte;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  point_index;
        logic [2:0]  touch_event;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic        touch_active;
        logic [2:0]  points_in_report;
    } out_t;

endpackage

/* src/tred_slot_store.sv */
`timescale 1ns / 1ps

module tred_slot_store #(
    parameter int DEPTH  = 5,
    parameter int SLOT_W = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_slot,
    input  logic [11:0]       wr_x,
    input  logic [11:0]       wr_y,
    input  logic [SLOT_W-1:0] rd_slot,
    output logic [11:0]       rd_x,
    output logic [11:0]       rd_y
);

    logic [11:0] x_reg [DEPTH];
    logic [11:0] y_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                x_reg[i] <= '0;
                y_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            x_reg[wr_slot] <= wr_x;
            y_reg[wr_slot] <= wr_y;
        end
    end

    assign rd_x = x_reg[rd_slot];
    assign rd_y = y_reg[rd_slot];

endmodule

/* src/tred_out_skid.sv */
`timescale 1ns / 1ps

module tred_out_skid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tred_pkg::out_t push_data,
    output logic           full,
    output logic           valid,
    input  logic           stall,
    output tred_pkg::out_t data
);

    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    tred_pkg::out_t out_reg, out_next;
    tred_pkg::out_t skid_reg, skid_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || !stall)
        begin
            // advance: skid first, else the fresh result
            out_valid_next  = skid_valid_reg | push;
            out_next        = skid_valid_reg ? skid_reg : push_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            // hold the fresh result behind the stalled one
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full  = skid_valid_reg;
    assign valid = out_valid_reg;
    assign data  = out_reg;

endmodule

/* src/touch_report_event_decoder.sv */
`timescale 1ns / 1ps

// Touch report event decoder. Takes a touch-controller report one byte per
// transfer on the item channel: a status byte flagged by first_byte (low
// nibble = point count, saturated to MAX_POINTS) and then MAX_POINTS six-byte
// point records, 1 + 6*MAX_POINTS bytes in all. Record byte 3 of each counted
// point yields a point result (down, up, hold, move or none, judged against
// the coordinates last seen in that slot); the final byte of the report
// yields a summary with the active flag and the published position (last
// active point, else last counted point, else unchanged). A transfer with
// kind set marks a failed read: it aborts the report, clears the active flag
// and yields a summary at once. A first_byte with kind clear always restarts
// a report; bytes arriving outside a report are dropped. Every byte is decoded
// combinationally by the parse logic, so one transfer is taken per clock while
// the item channel is not stalled. Each result is registered in the two-entry
// result side: the output register, or its skid entry while the result channel
// stalls. The item channel stalls only while that skid entry is occupied.

module touch_report_event_decoder #(
    parameter int MAX_POINTS = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  tred_pkg::in_t item,
    output logic          result_valid,
    input  logic          result_stall,
    output tred_pkg::out_t result
);

    localparam int SLOT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_POINTS - 1);
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_POINTS);

    // Parse position: idle flag, record slot and offset within the record
    logic              idle_reg, idle_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [2:0]        off_reg, off_next;
    logic [CNT_W-1:0]  points_reg, points_next;
    logic              active_reg, active_next;
    logic [11:0]       pend_x_reg, pend_x_next;
    logic [1:0]        pend_code_reg, pend_code_next;
    logic [3:0]        pend_yh_reg, pend_yh_next;
    logic [11:0]       pub_x_reg, pub_x_next;
    logic [11:0]       pub_y_reg, pub_y_next;
    logic [11:0]       last_x_reg, last_x_next;
    logic [11:0]       last_y_reg, last_y_next;

    logic              accept;
    logic              res_push;
    tred_pkg::out_t    res;
    logic              st_wr;
    logic [11:0]       st_x, st_y;
    logic [11:0]       new_x, new_y;
    logic              counted;
    logic              last_byte;
    logic [3:0]        nibble;
    logic [31:0]       slot_ext, points_ext;

    assign accept     = item_valid && !item_stall;
    assign new_x      = pend_x_reg;
    assign new_y      = {pend_yh_reg, item.data_byte};
    assign nibble     = item.data_byte[3:0] & tred_pkg::COUNT_MASK;
    assign slot_ext   = 32'(slot_reg);
    assign points_ext = 32'(points_reg);
    assign counted    = slot_ext < points_ext;
    assign last_byte  = (slot_reg == LAST_SLOT) && (off_reg == tred_pkg::OFF_LAST);

    tred_slot_store #(
        .DEPTH  (MAX_POINTS),
        .SLOT_W (SLOT_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (st_wr),
        .wr_slot (slot_reg),
        .wr_x    (new_x),
        .wr_y    (new_y),
        .rd_slot (slot_reg),
        .rd_x    (st_x),
        .rd_y    (st_y)
    );

    always_comb
    begin
        idle_next      = idle_reg;
        slot_next      = slot_reg;
        off_next       = off_reg;
        points_next    = points_reg;
        active_next    = active_reg;
        pend_x_next    = pend_x_reg;
        pend_code_next = pend_code_reg;
        pend_yh_next   = pend_yh_reg;
        pub_x_next     = pub_x_reg;
        pub_y_next     = pub_y_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        st_wr          = 1'b0;
        res_push       = 1'b0;
        res            = '0;

        if (accept)
        begin
            if (item.kind == tred_pkg::KIND_FAIL)
            begin
                // drop the report in progress and report inactive
                idle_next            = 1'b1;
                points_next          = '0;
                active_next          = 1'b0;
                res_push             = 1'b1;
                res.result_kind      = tred_pkg::RK_SUMMARY;
                res.x_pos            = pub_x_reg;
                res.y_pos            = pub_y_reg;
            end
            else if (item.first_byte)
            begin
                points_next = (32'(nibble) > 32'(MAX_POINTS)) ? MAX_CNT : CNT_W'(nibble);
                active_next = 1'b0;
                last_x_next = pub_x_reg;
                last_y_next = pub_y_reg;
                idle_next   = 1'b0;
                slot_next   = '0;
                off_next    = '0;
            end
            else if (!idle_reg)
            begin
                if (counted)
                begin
                    case (off_reg)
                        tred_pkg::OFF_X_HIGH:
                        begin
                            pend_x_next    = {item.data_byte[3:0], 8'h00};
                            pend_code_next = item.data_byte[7:6];
                        end
                        tred_pkg::OFF_X_LOW:
                            pend_x_next = {pend_x_reg[11:8], item.data_byte};
                        tred_pkg::OFF_Y_HIGH:
                            pend_yh_next = item.data_byte[3:0];
                        tred_pkg::OFF_Y_LOW:
                        begin
                            st_wr                = 1'b1;
                            last_x_next          = new_x;
                            last_y_next          = new_y;
                            res_push             = 1'b1;
                            res.result_kind      = tred_pkg::RK_POINT;
                            res.point_index      = slot_ext[2:0];
                            res.x_pos            = new_x;
                            res.y_pos            = new_y;
                            res.points_in_report = points_ext[2:0];
                            unique case (pend_code_reg)
                                tred_pkg::CODE_DOWN:
                                    res.touch_event = tred_pkg::EV_DOWN;
                                tred_pkg::CODE_UP:
                                    res.touch_event = tred_pkg::EV_UP;
                                tred_pkg::CODE_CONTACT:
                                    res.touch_event = (st_x != new_x || st_y != new_y)
                                                      ? tred_pkg::EV_MOVE
                                                      : tred_pkg::EV_HOLD;
                                default:
                                    res.touch_event = tred_pkg::EV_NONE;
                            endcase
                            // down or contact makes the point active
                            if (pend_code_reg == tred_pkg::CODE_DOWN ||
                                pend_code_reg == tred_pkg::CODE_CONTACT)
                            begin
                                active_next = 1'b1;
                                pub_x_next  = new_x;
                                pub_y_next  = new_y;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (last_byte)
                begin
                    // no active point: publish the release position
                    if (!active_reg && points_reg != '0)
                    begin
                        pub_x_next = last_x_reg;
                        pub_y_next = last_y_reg;
                    end
                    res_push             = 1'b1;
                    res                  = '0;
                    res.result_kind      = tred_pkg::RK_SUMMARY;
                    res.x_pos            = (!active_reg && points_reg != '0)
                                           ? last_x_reg : pub_x_reg;
                    res.y_pos            = (!active_reg && points_reg != '0)
                                           ? last_y_reg : pub_y_reg;
                    res.touch_active     = active_reg;
                    res.points_in_report = points_ext[2:0];
                    idle_next            = 1'b1;
                end

                // advance through the record
                if (off_reg == tred_pkg::OFF_LAST)
                begin
                    off_next  = '0;
                    slot_next = slot_reg + SLOT_W'(1);
                end
                else
                begin
                    off_next = off_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg      <= 1'b1;
            slot_reg      <= '0;
            off_reg       <= '0;
            points_reg    <= '0;
            active_reg    <= 1'b0;
            pend_x_reg    <= '0;
            pend_code_reg <= '0;
            pend_yh_reg   <= '0;
            pub_x_reg     <= '0;
            pub_y_reg     <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
        end
        else
        begin
            idle_reg      <= idle_next;
            slot_reg      <= slot_next;
            off_reg       <= off_next;
            points_reg    <= points_next;
            active_reg    <= active_next;
            pend_x_reg    <= pend_x_next;
            pend_code_reg <= pend_code_next;
            pend_yh_reg   <= pend_yh_next;
            pub_x_reg     <= pub_x_next;
            pub_y_reg     <= pub_y_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
        end
    end

    // Result register with skid; stall the item channel while the skid holds
    tred_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .full      (item_stall),
        .valid     (result_valid),
        .stall     (result_stall),
        .data      (result)
    );

endmodule
